### rtl/core/nst_pkg.sv
// NAT session state tracker: shared types and constants.
// Holds command, protocol, flag, history and register codes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nst_pkg;

  typedef enum logic [1:0] {
    CMD_INIT    = 2'd0,
    CMD_PACKET  = 2'd1,
    CMD_TIMEOUT = 2'd2,
    CMD_CLOSE   = 2'd3
  } cmd_e;

  localparam logic [1:0] PROTO_TCP   = 2'd0;
  localparam logic [1:0] PROTO_UDP   = 2'd1;
  localparam logic [1:0] PROTO_OTHER = 2'd2;

  // one-hot session states
  typedef enum logic [6:0] {
    ST_CLOSED = 7'b0000001,
    ST_INIT   = 7'b0000010,
    ST_ESTD   = 7'b0000100,
    ST_TRANS  = 7'b0001000,
    ST_FFIN   = 7'b0010000,
    ST_BFIN   = 7'b0100000,
    ST_BOTH   = 7'b1000000
  } sess_state_e;

  localparam logic [2:0] CODE_CLOSED = 3'd0;
  localparam logic [2:0] CODE_INIT   = 3'd1;
  localparam logic [2:0] CODE_ESTD   = 3'd2;
  localparam logic [2:0] CODE_TRANS  = 3'd3;
  localparam logic [2:0] CODE_FFIN   = 3'd4;
  localparam logic [2:0] CODE_BFIN   = 3'd5;
  localparam logic [2:0] CODE_BOTH   = 3'd6;

  typedef enum logic [2:0] {
    EV_NONE = 3'd0,
    EV_SYN  = 3'd1,
    EV_RST  = 3'd2,
    EV_ACK  = 3'd3,
    EV_FIN  = 3'd4
  } tcp_ev_e;

  localparam int unsigned FL_FIN = 0;
  localparam int unsigned FL_SYN = 1;
  localparam int unsigned FL_RST = 2;
  localparam int unsigned FL_ACK = 4;

  localparam int unsigned HB_ESTD = 0;
  localparam int unsigned HB_FFIN = 1;
  localparam int unsigned HB_BFIN = 2;
  localparam int unsigned HB_FRST = 3;
  localparam int unsigned HB_BRST = 4;
  localparam int unsigned HB_FACK = 5;
  localparam int unsigned HB_BACK = 6;

  localparam int unsigned TIME_W = 17;
  localparam int unsigned RTT_W  = 32;
  localparam int unsigned HIST_W = 7;
  localparam int unsigned CFG_IDX_W = 3;

  typedef logic [TIME_W-1:0] time_t;

  localparam logic [CFG_IDX_W-1:0] REG_TCP_OPEN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TCP_ESTD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TCP_CLOSE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UDP_OPEN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UDP_ESTD  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OTH_OPEN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OTH_ESTD  = 3'd6;

  localparam time_t RST_TCP_OPEN  = 17'd240;
  localparam time_t RST_TCP_ESTD  = 17'd7440;
  localparam time_t RST_TCP_CLOSE = 17'd240;
  localparam time_t RST_UDP_OPEN  = 17'd30;
  localparam time_t RST_UDP_ESTD  = 17'd300;
  localparam time_t RST_OTH_OPEN  = 17'd30;
  localparam time_t RST_OTH_ESTD  = 17'd240;

  function automatic logic [2:0] state_code(sess_state_e s);
    logic [2:0] c;
    case (s)
      ST_CLOSED: c = CODE_CLOSED;
      ST_INIT:   c = CODE_INIT;
      ST_ESTD:   c = CODE_ESTD;
      ST_TRANS:  c = CODE_TRANS;
      ST_FFIN:   c = CODE_FFIN;
      ST_BFIN:   c = CODE_BFIN;
      ST_BOTH:   c = CODE_BOTH;
      default:   c = CODE_CLOSED;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/core/nat_session_state_tracker_core.sv
// NAT session state tracker core: one session, TCP seven-state and non-TCP machines.
// Items pass the input register, then the result register; a result stall holds them between.
// Throughput: one item per cycle unless the result side stalls.
// Reset: asynchronous active low; state closed, protocol other, history and RTTs zero,
// expiry registers at their defaults. Depends on nst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nat_session_state_tracker_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // input items
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire logic [1:0]   cmd_i,
  input  wire logic [1:0]   protocol_i,
  input  wire logic         direction_i,
  input  wire logic [7:0]   tcp_flags_i,
  input  wire logic [63:0]  now_usecs_i,
  input  wire logic [63:0]  start_usecs_i,
  input  wire logic [16:0]  port_override_time_i,
  // result items
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic [2:0]        session_state_o,
  output logic              is_closed_o,
  output logic [6:0]        history_o,
  output logic [31:0]       external_rtt_o,
  output logic [31:0]       internal_rtt_o,
  output logic [16:0]       expiry_time_o,
  // configuration writes
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [2:0]   cfg_index_i,
  input  wire logic [16:0]  cfg_data_i
);

  // config registers
  nst_pkg::time_t tcp_open_q, tcp_estd_q, tcp_close_q;
  nst_pkg::time_t udp_open_q, udp_estd_q, oth_open_q, oth_estd_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tcp_open_q  <= nst_pkg::RST_TCP_OPEN;
      tcp_estd_q  <= nst_pkg::RST_TCP_ESTD;
      tcp_close_q <= nst_pkg::RST_TCP_CLOSE;
      udp_open_q  <= nst_pkg::RST_UDP_OPEN;
      udp_estd_q  <= nst_pkg::RST_UDP_ESTD;
      oth_open_q  <= nst_pkg::RST_OTH_OPEN;
      oth_estd_q  <= nst_pkg::RST_OTH_ESTD;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        nst_pkg::REG_TCP_OPEN:  tcp_open_q  <= cfg_data_i;
        nst_pkg::REG_TCP_ESTD:  tcp_estd_q  <= cfg_data_i;
        nst_pkg::REG_TCP_CLOSE: tcp_close_q <= cfg_data_i;
        nst_pkg::REG_UDP_OPEN:  udp_open_q  <= cfg_data_i;
        nst_pkg::REG_UDP_ESTD:  udp_estd_q  <= cfg_data_i;
        nst_pkg::REG_OTH_OPEN:  oth_open_q  <= cfg_data_i;
        nst_pkg::REG_OTH_ESTD:  oth_estd_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  logic                 in_vld_q;
  nst_pkg::cmd_e        cmd_q;
  logic [1:0]           proto_in_q;
  logic                 dir_q;
  logic [7:0]           flags_q;
  logic [31:0]          diff_q;
  nst_pkg::time_t       over_q;

  logic out_free;
  logic process;
  logic in_take;

  assign out_free   = !out_valid_o || !out_stall_i;
  assign process    = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (process) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q      <= nst_pkg::cmd_e'(cmd_i);
      proto_in_q <= protocol_i;
      dir_q      <= direction_i;
      flags_q    <= tcp_flags_i;
      diff_q     <= now_usecs_i[31:0] - start_usecs_i[31:0];
      over_q     <= port_override_time_i;
    end
  end

  // session state
  nst_pkg::sess_state_e state_q, state_d, tcp_nx;
  logic [1:0]           proto_q, proto_d;
  logic [6:0]           hist_q, hist_d;
  logic [31:0]          ext_q, ext_d, int_q, int_d;
  nst_pkg::tcp_ev_e     ev;

  always_comb begin
    if (flags_q[nst_pkg::FL_RST]) begin
      ev = nst_pkg::EV_RST;
    end else if (flags_q[nst_pkg::FL_SYN]) begin
      ev = nst_pkg::EV_SYN;
    end else if (flags_q[nst_pkg::FL_FIN]) begin
      ev = nst_pkg::EV_FIN;
    end else if (flags_q[nst_pkg::FL_ACK]) begin
      ev = nst_pkg::EV_ACK;
    end else begin
      ev = nst_pkg::EV_NONE;
    end
  end

  always_comb begin
    tcp_nx = state_q;
    case (state_q)
      nst_pkg::ST_CLOSED: begin
        if (!dir_q && ev == nst_pkg::EV_SYN) tcp_nx = nst_pkg::ST_INIT;
      end
      nst_pkg::ST_INIT: begin
        if (dir_q && ev == nst_pkg::EV_SYN) tcp_nx = nst_pkg::ST_ESTD;
      end
      nst_pkg::ST_ESTD: begin
        if (ev == nst_pkg::EV_RST) begin
          tcp_nx = nst_pkg::ST_TRANS;
        end else if (ev == nst_pkg::EV_FIN) begin
          tcp_nx = dir_q ? nst_pkg::ST_BFIN : nst_pkg::ST_FFIN;
        end
      end
      nst_pkg::ST_TRANS: begin
        if (!dir_q && ev == nst_pkg::EV_ACK) tcp_nx = nst_pkg::ST_ESTD;
      end
      nst_pkg::ST_FFIN: begin
        if (dir_q && ev == nst_pkg::EV_FIN) tcp_nx = nst_pkg::ST_BOTH;
      end
      nst_pkg::ST_BFIN: begin
        if (!dir_q && ev == nst_pkg::EV_FIN) tcp_nx = nst_pkg::ST_BOTH;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    proto_d = proto_q;
    hist_d  = hist_q;
    ext_d   = ext_q;
    int_d   = int_q;
    case (cmd_q)
      nst_pkg::CMD_INIT: begin
        proto_d = proto_in_q;
        state_d = nst_pkg::ST_CLOSED;
        hist_d  = '0;
        ext_d   = '0;
        int_d   = '0;
      end
      nst_pkg::CMD_PACKET: begin
        if (proto_q != nst_pkg::PROTO_TCP) begin
          if (state_q == nst_pkg::ST_CLOSED && !dir_q) begin
            state_d = nst_pkg::ST_INIT;
          end else if (state_q == nst_pkg::ST_INIT && dir_q) begin
            state_d = nst_pkg::ST_ESTD;
          end
        end else begin
          case (ev)
            nst_pkg::EV_RST: begin
              if (dir_q) hist_d[nst_pkg::HB_BRST] = 1'b1;
              else       hist_d[nst_pkg::HB_FRST] = 1'b1;
            end
            nst_pkg::EV_SYN: begin
              if (dir_q && flags_q[nst_pkg::FL_ACK]) ext_d = diff_q;
            end
            nst_pkg::EV_FIN: begin
              if (dir_q) hist_d[nst_pkg::HB_BFIN] = 1'b1;
              else       hist_d[nst_pkg::HB_FFIN] = 1'b1;
            end
            nst_pkg::EV_ACK: begin
              if (dir_q) begin
                hist_d[nst_pkg::HB_BACK] = 1'b1;
              end else if (!hist_q[nst_pkg::HB_FACK]) begin
                hist_d[nst_pkg::HB_FACK] = 1'b1;
                int_d = diff_q - ext_q;
              end
            end
            default: ;
          endcase
          state_d = tcp_nx;
          // ESTD is only entered from another state
          if (tcp_nx == nst_pkg::ST_ESTD && state_q != nst_pkg::ST_ESTD) begin
            hist_d[nst_pkg::HB_ESTD] = 1'b1;
          end
        end
      end
      nst_pkg::CMD_TIMEOUT: begin
        if (proto_q == nst_pkg::PROTO_TCP) begin
          if (state_q == nst_pkg::ST_ESTD) state_d = nst_pkg::ST_TRANS;
          else                             state_d = nst_pkg::ST_CLOSED;
        end else if (state_q == nst_pkg::ST_INIT || state_q == nst_pkg::ST_ESTD) begin
          state_d = nst_pkg::ST_CLOSED;
        end
      end
      nst_pkg::CMD_CLOSE: begin
        state_d = nst_pkg::ST_CLOSED;
      end
      default: ;
    endcase
  end

  // expiry of the resulting state
  nst_pkg::time_t expiry_d;
  logic           is_estd, is_init;

  assign is_estd = (state_d == nst_pkg::ST_ESTD);
  assign is_init = (state_d == nst_pkg::ST_INIT);

  always_comb begin
    if (state_d == nst_pkg::ST_CLOSED) begin
      expiry_d = '0;
    end else if (proto_d == nst_pkg::PROTO_TCP) begin
      if (is_estd)      expiry_d = (over_q != '0) ? over_q : tcp_estd_q;
      else if (is_init) expiry_d = tcp_open_q;
      else              expiry_d = tcp_close_q;
    end else if (proto_d == nst_pkg::PROTO_UDP) begin
      expiry_d = is_estd ? ((over_q != '0) ? over_q : udp_estd_q) : udp_open_q;
    end else begin
      expiry_d = is_estd ? oth_estd_q : oth_open_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nst_pkg::ST_CLOSED;
      proto_q     <= nst_pkg::PROTO_OTHER;
      hist_q      <= '0;
      ext_q       <= '0;
      int_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (process) begin
        state_q <= state_d;
        proto_q <= proto_d;
        hist_q  <= hist_d;
        ext_q   <= ext_d;
        int_q   <= int_d;
      end
      if (process) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (process) begin
      session_state_o <= nst_pkg::state_code(state_d);
      is_closed_o     <= (state_d == nst_pkg::ST_CLOSED);
      history_o       <= hist_d;
      external_rtt_o  <= ext_d;
      internal_rtt_o  <= int_d;
      expiry_time_o   <= expiry_d;
    end
  end

  // checks
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("session state register not one-hot");

  a_closed_no_expiry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_closed_o |-> expiry_time_o == '0)
    else $error("closed session reports nonzero expiry");

  a_process_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    process |=> out_valid_o)
    else $error("processed item produced no result");

  a_init_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    process && cmd_q == nst_pkg::CMD_INIT |=> hist_q == '0 && ext_q == '0 && int_q == '0)
    else $error("init did not clear history and round-trip times");

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps
// Testbench for nat_session_state_tracker_core: a directed item table, then random session
// traffic under several expiry settings, scored against typed rows or an in-bench session model.
// Depends on nst_pkg and the core RTL only.

module tb_top;

  localparam int unsigned    CYCLE_LIMIT     = 400000;
  localparam int unsigned    ITEMS_PER_PHASE = 180;
  localparam int unsigned    SETTLE_CYCLES   = 8;
  localparam int unsigned    PRESSURE_AT     = 400;
  localparam int unsigned    PRESSURE_CYCLES = 120;
  localparam int unsigned    QUIET_FROM      = 600;
  localparam int unsigned    QUIET_TO        = 750;
  localparam nst_pkg::time_t TIME_MAX        = 17'd86400;

  localparam logic FWD  = 1'b0;
  localparam logic BACK = 1'b1;

  localparam logic [7:0] M_FIN = 8'd1 << nst_pkg::FL_FIN;
  localparam logic [7:0] M_SYN = 8'd1 << nst_pkg::FL_SYN;
  localparam logic [7:0] M_RST = 8'd1 << nst_pkg::FL_RST;
  localparam logic [7:0] M_ACK = 8'd1 << nst_pkg::FL_ACK;

  typedef struct packed {
    nst_pkg::cmd_e  cmd;
    logic [1:0]     proto;
    logic           dir;
    logic [7:0]     flags;
    logic [63:0]    now;
    logic [63:0]    start;
    nst_pkg::time_t over;
  } pkt_t;

  typedef struct packed {
    logic [2:0]     code;
    logic           closed;
    logic [6:0]     hist;
    logic [31:0]    ext_rtt;
    logic [31:0]    int_rtt;
    nst_pkg::time_t expiry;
  } sess_rslt_t;

  typedef struct packed {
    pkt_t       pkt;
    logic       typed;
    sess_rslt_t want;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  cmd_i;
  logic [1:0]  protocol_i;
  logic        direction_i;
  logic [7:0]  tcp_flags_i;
  logic [63:0] now_usecs_i;
  logic [63:0] start_usecs_i;
  logic [16:0] port_override_time_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  session_state_o;
  logic        is_closed_o;
  logic [6:0]  history_o;
  logic [31:0] external_rtt_o;
  logic [31:0] internal_rtt_o;
  logic [16:0] expiry_time_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [16:0] cfg_data_i;

  // session model state
  logic [2:0]     trk_state;
  logic [1:0]     trk_proto;
  logic [6:0]     trk_hist;
  logic [31:0]    trk_ext;
  logic [31:0]    trk_int;
  nst_pkg::time_t tmo_cfg [nst_pkg::REG_TCP_OPEN:nst_pkg::REG_OTH_ESTD];

  sess_rslt_t  session_expected [$];
  row_t        directed_rows [$];
  int unsigned accepted_cnt;
  int unsigned fail_cnt;
  int unsigned cycle_cnt;

  nat_session_state_tracker_core uut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .cmd_i                (cmd_i),
    .protocol_i           (protocol_i),
    .direction_i          (direction_i),
    .tcp_flags_i          (tcp_flags_i),
    .now_usecs_i          (now_usecs_i),
    .start_usecs_i        (start_usecs_i),
    .port_override_time_i (port_override_time_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .session_state_o      (session_state_o),
    .is_closed_o          (is_closed_o),
    .history_o            (history_o),
    .external_rtt_o       (external_rtt_o),
    .internal_rtt_o       (internal_rtt_o),
    .expiry_time_o        (expiry_time_o),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic bit quiet_span();
    return accepted_cnt >= QUIET_FROM && accepted_cnt < QUIET_TO;
  endfunction

  function automatic sess_rslt_t track_session(pkt_t p);
    sess_rslt_t        r;
    nst_pkg::tcp_ev_e  ev;
    logic [2:0]        nx;
    logic [63:0]       span;
    int unsigned       hb;
    span = p.now - p.start;
    case (p.cmd)
      nst_pkg::CMD_INIT: begin
        trk_proto = p.proto;
        trk_state = nst_pkg::CODE_CLOSED;
        trk_hist  = '0;
        trk_ext   = '0;
        trk_int   = '0;
      end
      nst_pkg::CMD_PACKET: begin
        if (trk_proto != nst_pkg::PROTO_TCP) begin
          if (trk_state == nst_pkg::CODE_CLOSED && p.dir == FWD) begin
            trk_state = nst_pkg::CODE_INIT;
          end else if (trk_state == nst_pkg::CODE_INIT && p.dir == BACK) begin
            trk_state = nst_pkg::CODE_ESTD;
          end
        end else begin
          ev = nst_pkg::EV_NONE;
          if (p.flags[nst_pkg::FL_RST]) begin
            ev = nst_pkg::EV_RST;
            trk_hist[p.dir ? nst_pkg::HB_BRST : nst_pkg::HB_FRST] = 1'b1;
          end else if (p.flags[nst_pkg::FL_SYN]) begin
            ev = nst_pkg::EV_SYN;
            if (p.dir == BACK && p.flags[nst_pkg::FL_ACK]) trk_ext = span[31:0];
          end else if (p.flags[nst_pkg::FL_FIN]) begin
            ev = nst_pkg::EV_FIN;
            trk_hist[p.dir ? nst_pkg::HB_BFIN : nst_pkg::HB_FFIN] = 1'b1;
          end else if (p.flags[nst_pkg::FL_ACK]) begin
            ev = nst_pkg::EV_ACK;
            hb = p.dir ? nst_pkg::HB_BACK : nst_pkg::HB_FACK;
            if (!trk_hist[hb]) begin
              trk_hist[hb] = 1'b1;
              if (p.dir == FWD) trk_int = span[31:0] - trk_ext;
            end
          end
          nx = trk_state;
          case (trk_state)
            nst_pkg::CODE_CLOSED:
              if (p.dir == FWD && ev == nst_pkg::EV_SYN) nx = nst_pkg::CODE_INIT;
            nst_pkg::CODE_INIT:
              if (p.dir == BACK && ev == nst_pkg::EV_SYN) nx = nst_pkg::CODE_ESTD;
            nst_pkg::CODE_ESTD:
              if (ev == nst_pkg::EV_RST) nx = nst_pkg::CODE_TRANS;
              else if (ev == nst_pkg::EV_FIN) nx = p.dir ? nst_pkg::CODE_BFIN
                                                         : nst_pkg::CODE_FFIN;
            nst_pkg::CODE_TRANS:
              if (p.dir == FWD && ev == nst_pkg::EV_ACK) nx = nst_pkg::CODE_ESTD;
            nst_pkg::CODE_FFIN:
              if (p.dir == BACK && ev == nst_pkg::EV_FIN) nx = nst_pkg::CODE_BOTH;
            nst_pkg::CODE_BFIN:
              if (p.dir == FWD && ev == nst_pkg::EV_FIN) nx = nst_pkg::CODE_BOTH;
            default: nx = trk_state;
          endcase
          if (nx != trk_state) begin
            trk_state = nx;
            if (nx == nst_pkg::CODE_ESTD) trk_hist[nst_pkg::HB_ESTD] = 1'b1;
          end
        end
      end
      nst_pkg::CMD_TIMEOUT: begin
        if (trk_proto == nst_pkg::PROTO_TCP) begin
          if (trk_state == nst_pkg::CODE_ESTD) begin
            trk_state = nst_pkg::CODE_TRANS;
          end else if (trk_state != nst_pkg::CODE_CLOSED && trk_state <= nst_pkg::CODE_BOTH) begin
            trk_state = nst_pkg::CODE_CLOSED;
          end
        end else if (trk_state == nst_pkg::CODE_INIT || trk_state == nst_pkg::CODE_ESTD) begin
          trk_state = nst_pkg::CODE_CLOSED;
        end
      end
      default: trk_state = nst_pkg::CODE_CLOSED;
    endcase

    r.code    = trk_state;
    r.closed  = trk_state == nst_pkg::CODE_CLOSED;
    r.hist    = trk_hist;
    r.ext_rtt = trk_ext;
    r.int_rtt = trk_int;
    r.expiry  = '0;
    if (trk_state != nst_pkg::CODE_CLOSED) begin
      if (trk_state == nst_pkg::CODE_ESTD) begin
        if (trk_proto == nst_pkg::PROTO_TCP) begin
          r.expiry = p.over != 0 ? p.over : tmo_cfg[nst_pkg::REG_TCP_ESTD];
        end else if (trk_proto == nst_pkg::PROTO_UDP) begin
          r.expiry = p.over != 0 ? p.over : tmo_cfg[nst_pkg::REG_UDP_ESTD];
        end else begin
          r.expiry = tmo_cfg[nst_pkg::REG_OTH_ESTD];
        end
      end else if (trk_proto == nst_pkg::PROTO_TCP) begin
        r.expiry = trk_state == nst_pkg::CODE_INIT ? tmo_cfg[nst_pkg::REG_TCP_OPEN]
                                                   : tmo_cfg[nst_pkg::REG_TCP_CLOSE];
      end else if (trk_proto == nst_pkg::PROTO_UDP) begin
        r.expiry = tmo_cfg[nst_pkg::REG_UDP_OPEN];
      end else begin
        r.expiry = tmo_cfg[nst_pkg::REG_OTH_OPEN];
      end
    end
    return r;
  endfunction

  // mostly legal next steps for the current session, the rest noise
  function automatic pkt_t next_random_item();
    pkt_t             p;
    nst_pkg::tcp_ev_e ev;
    int unsigned      pick;
    int unsigned      sub;
    p.cmd   = nst_pkg::CMD_PACKET;
    p.proto = 2'($urandom_range(0, 3));
    p.dir   = 1'($urandom_range(0, 1));
    p.flags = 8'($urandom);
    p.start = {$urandom, $urandom};
    p.now   = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                          : p.start + $urandom_range(0, 200000);
    sub = $urandom_range(0, 99);
    p.over = sub < 25 ? nst_pkg::time_t'(0)
           : sub < 85 ? nst_pkg::time_t'($urandom_range(1, TIME_MAX))
                      : nst_pkg::time_t'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      p.cmd   = nst_pkg::CMD_INIT;
      p.proto = ($urandom_range(0, 1) == 0) ? nst_pkg::PROTO_TCP : 2'($urandom_range(1, 3));
    end else if (pick < 11) begin
      p.cmd = nst_pkg::CMD_TIMEOUT;
    end else if (pick < 14) begin
      p.cmd = nst_pkg::CMD_CLOSE;
    end else if (pick >= 30) begin
      if (trk_proto != nst_pkg::PROTO_TCP) begin
        p.dir = (trk_state == nst_pkg::CODE_CLOSED) ? FWD : BACK;
      end else begin
        ev = nst_pkg::EV_NONE;
        sub = $urandom_range(0, 5);
        case (trk_state)
          nst_pkg::CODE_CLOSED: begin
            p.dir = FWD;
            ev = nst_pkg::EV_SYN;
          end
          nst_pkg::CODE_INIT: begin
            p.dir = BACK;
            ev = nst_pkg::EV_SYN;
          end
          nst_pkg::CODE_ESTD: begin
            case (sub)
              0:       ev = nst_pkg::EV_RST;
              1:       ev = nst_pkg::EV_FIN;
              2, 3:    ev = nst_pkg::EV_ACK;
              4:       ev = nst_pkg::EV_NONE;
              default: ev = nst_pkg::EV_SYN;
            endcase
          end
          nst_pkg::CODE_TRANS: begin
            p.dir = FWD;
            ev = nst_pkg::EV_ACK;
          end
          nst_pkg::CODE_FFIN: begin
            p.dir = BACK;
            ev = nst_pkg::EV_FIN;
          end
          nst_pkg::CODE_BFIN: begin
            p.dir = FWD;
            ev = nst_pkg::EV_FIN;
          end
          default: p.cmd = nst_pkg::CMD_TIMEOUT;
        endcase
        case (ev)
          nst_pkg::EV_RST: p.flags = p.flags | M_RST;
          nst_pkg::EV_SYN: begin
            p.flags = (p.flags & ~M_RST) | M_SYN;
            if (trk_state == nst_pkg::CODE_INIT && sub != 0) p.flags = p.flags | M_ACK;
          end
          nst_pkg::EV_FIN: p.flags = (p.flags & ~(M_RST | M_SYN)) | M_FIN;
          nst_pkg::EV_ACK: p.flags = (p.flags & ~(M_RST | M_SYN | M_FIN)) | M_ACK;
          default:         p.flags = p.flags & ~(M_RST | M_SYN | M_FIN | M_ACK);
        endcase
      end
    end
    return p;
  endfunction

  function automatic void add_row(pkt_t p, logic typed, sess_rslt_t want);
    row_t r;
    r.pkt   = p;
    r.typed = typed;
    r.want  = want;
    directed_rows.push_back(r);
  endfunction

  task automatic send_item(input pkt_t p, input logic typed, input sess_rslt_t want);
    sess_rslt_t pred;
    while (!quiet_span() && $urandom_range(0, 99) < 6) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    cmd_i                = p.cmd;
    protocol_i           = p.proto;
    direction_i          = p.dir;
    tcp_flags_i          = p.flags;
    now_usecs_i          = p.now;
    start_usecs_i        = p.start;
    port_override_time_i = p.over;
    in_valid_i           = 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pred = track_session(p);
    session_expected.push_back(typed ? want : pred);
    accepted_cnt++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input nst_pkg::time_t val);
    cfg_index_i = idx;
    cfg_data_i  = val;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    tmo_cfg[idx] = val;
    @(negedge clk_i);
  endtask

  task automatic settle();
    while (session_expected.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    sess_rslt_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (session_expected.size() == 0) begin
        $display("%0t: result with no item pending, state %0h", $time, session_state_o);
        fail_cnt++;
      end else begin
        want = session_expected.pop_front();
        check_field("session_state", want.code, session_state_o);
        check_field("is_closed", want.closed, is_closed_o);
        check_field("history", want.hist, history_o);
        check_field("external_rtt", want.ext_rtt, external_rtt_o);
        check_field("internal_rtt", want.int_rtt, internal_rtt_o);
        check_field("expiry_time", want.expiry, expiry_time_o);
      end
    end
  end

  // result side: random stalls, one long hold-off, one stretch with none
  initial begin
    int unsigned hold_left;
    bit          pressure_done;
    hold_left     = 0;
    pressure_done = 1'b0;
    out_stall_i   = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!pressure_done && accepted_cnt >= PRESSURE_AT) begin
        hold_left     = PRESSURE_CYCLES;
        pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else begin
        out_stall_i = !quiet_span() && ($urandom_range(0, 99) < 6);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, session_expected.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    nst_pkg::time_t val;
    row_t           r;
    accepted_cnt         = 0;
    fail_cnt             = 0;
    cycle_cnt            = 0;
    rst_ni               = 1'b0;
    in_valid_i           = 1'b0;
    cmd_i                = nst_pkg::CMD_INIT;
    protocol_i           = nst_pkg::PROTO_TCP;
    direction_i          = FWD;
    tcp_flags_i          = '0;
    now_usecs_i          = '0;
    start_usecs_i        = '0;
    port_override_time_i = '0;
    cfg_valid_i          = 1'b0;
    cfg_index_i          = nst_pkg::REG_TCP_OPEN;
    cfg_data_i           = '0;

    trk_state = nst_pkg::CODE_CLOSED;
    trk_proto = nst_pkg::PROTO_OTHER;
    trk_hist  = '0;
    trk_ext   = '0;
    trk_int   = '0;
    tmo_cfg[nst_pkg::REG_TCP_OPEN]  = nst_pkg::RST_TCP_OPEN;
    tmo_cfg[nst_pkg::REG_TCP_ESTD]  = nst_pkg::RST_TCP_ESTD;
    tmo_cfg[nst_pkg::REG_TCP_CLOSE] = nst_pkg::RST_TCP_CLOSE;
    tmo_cfg[nst_pkg::REG_UDP_OPEN]  = nst_pkg::RST_UDP_OPEN;
    tmo_cfg[nst_pkg::REG_UDP_ESTD]  = nst_pkg::RST_UDP_ESTD;
    tmo_cfg[nst_pkg::REG_OTH_OPEN]  = nst_pkg::RST_OTH_OPEN;
    tmo_cfg[nst_pkg::REG_OTH_ESTD]  = nst_pkg::RST_OTH_ESTD;

    // reset session is non-TCP with default expiry times
    add_row('{nst_pkg::CMD_CLOSE, nst_pkg::PROTO_TCP, FWD, 8'h00, 64'd0, 64'd0, 17'd0}, 1'b1,
            '{nst_pkg::CODE_CLOSED, 1'b1, 7'd0, 32'd0, 32'd0, 17'd0});
    add_row('{nst_pkg::CMD_PACKET, nst_pkg::PROTO_TCP, FWD, 8'h00, 64'd10, 64'd0, 17'd0}, 1'b1,
            '{nst_pkg::CODE_INIT, 1'b0, 7'd0, 32'd0, 32'd0, 17'd30});
    add_row('{nst_pkg::CMD_PACKET, nst_pkg::PROTO_TCP, BACK, 8'hFF, 64'd20, 64'd0, TIME_MAX},
            1'b1, '{nst_pkg::CODE_ESTD, 1'b0, 7'd0, 32'd0, 32'd0, 17'd240});
    add_row('{nst_pkg::CMD_TIMEOUT, nst_pkg::PROTO_TCP, FWD, 8'h00, 64'd0, 64'd0, 17'd0}, 1'b1,
            '{nst_pkg::CODE_CLOSED, 1'b1, 7'd0, 32'd0, 32'd0, 17'd0});
    add_row('{nst_pkg::CMD_INIT, nst_pkg::PROTO_UDP, FWD, 8'h00, 64'd0, 64'd0, 17'd0}, 1'b1,
            '{nst_pkg::CODE_CLOSED, 1'b1, 7'd0, 32'd0, 32'd0, 17'd0});
    add_row('{nst_pkg::CMD_PACKET, nst_pkg::PROTO_TCP, FWD, 8'h02, 64'd0, 64'd0, 17'd0},
            1'b0, '0);
    add_row('{nst_pkg::CMD_PACKET, nst_pkg::PROTO_TCP, BACK, 8'h00, 64'd0, 64'd0, 17'd0},
            1'b0, '0);
    // override above the range passes straight through
    add_row('{nst_pkg::CMD_PACKET, nst_pkg::PROTO_TCP, BACK, 8'h00, 64'd0, 64'd0, 17'h1FFFF},
            1'b0, '0);
    add_row('{nst_pkg::CMD_INIT, nst_pkg::PROTO_TCP, FWD, 8'h00, 64'd0, 64'd0, 17'd0}, 1'b1,
            '{nst_pkg::CODE_CLOSED, 1'b1, 7'd0, 32'd0, 32'd0, 17'd0});
    add_row('{nst_pkg::CMD_PACKET, nst_pkg::PROTO_OTHER, FWD, M_SYN | M_FIN, '1, '1, 17'd0},
            1'b0, '0);
    add_row('{nst_pkg::CMD_PACKET, nst_pkg::PROTO_TCP, BACK, M_SYN | M_ACK, 64'd0, 64'd1,
              17'd0}, 1'b0, '0);
    add_row('{nst_pkg::CMD_PACKET, nst_pkg::PROTO_TCP, FWD, M_ACK, '1, 64'd0, 17'd5},
            1'b0, '0);
    add_row('{nst_pkg::CMD_PACKET, nst_pkg::PROTO_TCP, FWD, 8'hF0, 64'd500, 64'd7, 17'd0},
            1'b0, '0);
    add_row('{nst_pkg::CMD_PACKET, nst_pkg::PROTO_TCP, BACK, M_ACK, 64'd900, 64'd3, TIME_MAX},
            1'b0, '0);
    add_row('{nst_pkg::CMD_PACKET, nst_pkg::PROTO_TCP, FWD, 8'hFF, 64'd0, 64'd0, 17'd0},
            1'b0, '0);
    add_row('{nst_pkg::CMD_PACKET, nst_pkg::PROTO_TCP, FWD, M_ACK, 64'd0, 64'd0, 17'd0},
            1'b0, '0);
    add_row('{nst_pkg::CMD_TIMEOUT, nst_pkg::PROTO_TCP, FWD, 8'h00, 64'd0, 64'd0, 17'd0},
            1'b0, '0);
    add_row('{nst_pkg::CMD_PACKET, nst_pkg::PROTO_TCP, FWD, M_ACK | 8'h08, 64'd0, 64'd0,
              17'd0}, 1'b0, '0);
    add_row('{nst_pkg::CMD_PACKET, nst_pkg::PROTO_TCP, BACK, M_FIN | M_ACK, 64'd0, 64'd0,
              17'd0}, 1'b0, '0);
    add_row('{nst_pkg::CMD_PACKET, nst_pkg::PROTO_TCP, FWD, M_FIN, 64'd0, 64'd0, 17'd0},
            1'b0, '0);
    add_row('{nst_pkg::CMD_TIMEOUT, nst_pkg::PROTO_TCP, FWD, 8'h00, 64'd0, 64'd0, 17'd0},
            1'b0, '0);
    // history still records in the closed state
    add_row('{nst_pkg::CMD_PACKET, nst_pkg::PROTO_TCP, BACK, M_RST, 64'd0, 64'd0, 17'd0},
            1'b0, '0);
    add_row('{nst_pkg::CMD_INIT, 2'd3, FWD, 8'h00, 64'd0, 64'd0, 17'd0}, 1'b1,
            '{nst_pkg::CODE_CLOSED, 1'b1, 7'd0, 32'd0, 32'd0, 17'd0});
    add_row('{nst_pkg::CMD_PACKET, nst_pkg::PROTO_TCP, FWD, M_SYN, 64'd0, 64'd0, 17'h1FFFF},
            1'b0, '0);
    add_row('{nst_pkg::CMD_PACKET, nst_pkg::PROTO_TCP, BACK, 8'h00, 64'd0, 64'd0, 17'd77},
            1'b0, '0);

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    while (directed_rows.size() != 0) begin
      r = directed_rows.pop_front();
      send_item(r.pkt, r.typed, r.want);
    end
    for (int i = 0; i < ITEMS_PER_PHASE; i++) send_item(next_random_item(), 1'b0, '0);

    for (int ph = 0; ph < 5; ph++) begin
      in_valid_i = 1'b0;
      settle();
      for (int idx = nst_pkg::REG_TCP_OPEN; idx <= nst_pkg::REG_OTH_ESTD; idx++) begin
        case (ph)
          0:       val = '0;
          1:       val = TIME_MAX;
          2:       val = '1;
          default: val = nst_pkg::time_t'($urandom_range(0, TIME_MAX));
        endcase
        write_reg(idx[2:0], val);
      end
      cfg_valid_i = 1'b0;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) send_item(next_random_item(), 1'b0, '0);
    end

    in_valid_i = 1'b0;
    settle();
    if (fail_cnt == 0 && session_expected.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
